// ===== rtl/cbt_pkg.sv =====
// Package for the cartridge bank and IRQ timer block.
// Holds opcodes, register offsets, sizes and the structs shared by the modules.
// No dependencies.
package cbt_pkg;

	// Number of program window bank registers
	localparam int BANK_SLOTS = 8;
	localparam int BANK_IDX_W = $clog2(BANK_SLOTS);

	// Item opcodes
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_DOT   = 2'd3
	} op_t;

	// Register offsets within the 0x4000 page
	localparam logic [7:0] OFF_PORT_A = 8'h16;
	localparam logic [7:0] OFF_PORT_B = 8'h26;
	localparam logic [7:0] OFF_PCM    = 8'h27;
	localparam logic [7:0] OFF_MASK   = 8'h32;
	localparam logic [7:0] OFF_STATUS = 8'h33;
	localparam logic [7:0] OFF_CTRL   = 8'h34;
	localparam logic [7:0] OFF_RELOAD = 8'h35;
	localparam logic [7:0] OFF_COUNT  = 8'h36;
	localparam logic [7:0] OFF_BANK   = 8'h40;

	// Timer control bits
	localparam int CTRL_EN_BIT     = 7;
	localparam int CTRL_REPEAT_BIT = 6;
	localparam int CTRL_LINE_BIT   = 5;

	// Scanline clocking starts at this dot
	localparam logic [8:0] LINE_CLK_DOT = 9'd280;

	// Board variant that takes bank bit 8 from port B
	localparam logic [1:0] VARIANT_PORT_B = 2'd1;

	// Reset values
	localparam logic [7:0] MASK_RESET   = 8'hFF;
	localparam logic [7:0] PORT_B_RESET = 8'h80;

	// One word as it enters the timer
	typedef struct packed {
		logic       step;
		op_t        op;
		logic [7:0] off;
		logic [7:0] wd;
		logic [8:0] line;
		logic [8:0] dot;
	} cbt_cmd_t;

	// Timer register values after the current word
	typedef struct packed {
		logic [7:0] ctrl;
		logic [7:0] reload;
		logic [7:0] count;
		logic       flag;
	} cbt_tmr_t;

endpackage

// ===== rtl/cbt_in_if.sv =====
// Input channel of the cartridge bank and IRQ timer block.
// Valid/ready handshake with the command word fields; depends on nothing.
interface cbt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] reg_offset;
	logic [7:0] write_data;
	logic [2:0] bank_slot;
	logic [8:0] scanline;
	logic [8:0] ppu_dot;

	modport source (
		output valid, opcode, reg_offset, write_data, bank_slot, scanline, ppu_dot,
		input  ready
	);
	modport sink (
		input  valid, opcode, reg_offset, write_data, bank_slot, scanline, ppu_dot,
		output ready
	);
endinterface

// ===== rtl/cbt_out_if.sv =====
// Result channel of the cartridge bank and IRQ timer block.
// Valid/ready handshake with the result word fields; depends on nothing.
interface cbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_claimed;
	logic       irq_asserted;
	logic [8:0] bank_number;
	logic [7:0] audio_level;

	modport source (
		output valid, read_data, read_claimed, irq_asserted, bank_number, audio_level,
		input  ready
	);
	modport sink (
		input  valid, read_data, read_claimed, irq_asserted, bank_number, audio_level,
		output ready
	);
endinterface

// ===== rtl/cbt_timer.sv =====
// Prescaled IRQ down-counter with its control, reload and flag registers.
// Uses cbt_pkg; updated once per word that leaves the input stage.
module cbt_timer
	import cbt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cbt_cmd_t cmd,
	output cbt_tmr_t nxt
);

	logic [7:0] ctrl_q;
	logic [7:0] reload_q;
	logic [7:0] count_q;
	logic [7:0] presc_q;
	logic [8:0] last_line_q;
	logic       flag_q;

	logic [7:0] presc_n;
	logic [8:0] last_line_n;
	logic [7:0] presc_inc;
	logic [7:0] count_dec;
	logic       clk_en;

	assign presc_inc = presc_q + 8'd1;
	assign count_dec = count_q - 8'd1;

	// Next state for one word
	always_comb begin
		nxt.ctrl    = ctrl_q;
		nxt.reload  = reload_q;
		nxt.count   = count_q;
		nxt.flag    = flag_q;
		presc_n     = presc_q;
		last_line_n = last_line_q;
		clk_en      = 1'b0;
		unique case (cmd.op)
			OP_WRITE: begin
				if (cmd.off == OFF_MASK) begin
					if (cmd.wd[7]) nxt.flag = 1'b0;
				end else if (cmd.off == OFF_CTRL) begin
					nxt.ctrl = cmd.wd;
					if (!cmd.wd[CTRL_EN_BIT]) nxt.flag = 1'b0;
				end else if (cmd.off == OFF_RELOAD) begin
					nxt.reload = cmd.wd;
					nxt.count  = 8'd0;
					nxt.flag   = 1'b0;
				end
			end
			OP_READ: begin
			end
			OP_TICK: begin
				clk_en = !ctrl_q[CTRL_LINE_BIT];
			end
			OP_DOT: begin
				if (cmd.dot >= LINE_CLK_DOT && cmd.line != last_line_q
						&& ctrl_q[CTRL_LINE_BIT]) begin
					last_line_n = cmd.line;
					clk_en      = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Prescaler and counter; never in the same word as a write
		if (clk_en && ctrl_q[CTRL_EN_BIT]) begin
			presc_n = presc_inc;
			if (presc_inc >= {4'd0, ctrl_q[3:0]}) begin
				presc_n = 8'd0;
				if (count_q == 8'd0) begin
					nxt.count = reload_q;
				end else begin
					nxt.count = count_dec;
					if (count_dec == 8'd0) begin
						nxt.flag = 1'b1;
						if (!ctrl_q[CTRL_REPEAT_BIT]) nxt.ctrl[CTRL_EN_BIT] = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= 8'd0;
			reload_q    <= 8'd0;
			count_q     <= 8'd0;
			presc_q     <= 8'd0;
			last_line_q <= 9'd0;
			flag_q      <= 1'b0;
		end else if (cmd.step) begin
			ctrl_q      <= nxt.ctrl;
			reload_q    <= nxt.reload;
			count_q     <= nxt.count;
			presc_q     <= presc_n;
			last_line_q <= last_line_n;
			flag_q      <= nxt.flag;
		end
	end

endmodule

// ===== rtl/cartridge_bank_and_irq_timer.sv =====
// Cartridge bank and IRQ timer register block, top level.
// Uses cbt_pkg, cbt_in_if, cbt_out_if and cbt_timer.
//
// Every command word (CPU write, CPU read, CPU cycle tick or PPU dot event)
// yields exactly one result word with read data, read claim, IRQ line, the
// 9-bit bank number of the requested window and the PCM level, all taken after
// the word's own register update. Result valid rises once the word has passed
// the input register and then the result register: one input register, one
// result register, with the whole register update done between them. One
// word is taken per cycle while the result side keeps up; the input register
// holds one more word while a result waits. The user must write board_variant
// through cfg_we/cfg_wdata only while the block is idle; the block itself does
// not enforce this.
module cartridge_bank_and_irq_timer
	import cbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	cbt_in_if.sink     cmd,
	cbt_out_if.source  res
);

	// Input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] off_s1;
	logic [7:0] wd_s1;
	logic [2:0] slot_s1;
	logic [8:0] line_s1;
	logic [8:0] dot_s1;

	// Result stage
	logic       valid_s2;
	logic [7:0] rdata_s2;
	logic       claimed_s2;
	logic       irq_s2;
	logic [8:0] bank_s2;
	logic [7:0] audio_s2;

	// Block registers; bank registers kept twice, one copy per read port
	logic [1:0] variant_q;
	logic [7:0] bank_rd_q  [BANK_SLOTS];
	logic [7:0] bank_win_q [BANK_SLOTS];
	logic [7:0] pcm_q;
	logic [7:0] mask_q;
	logic [7:0] port_a_q;
	logic [7:0] port_b_q;

	logic [7:0] bank_win_n [BANK_SLOTS];
	logic [7:0] pcm_n;
	logic [7:0] mask_n;
	logic [7:0] port_a_n;
	logic [7:0] port_b_n;

	logic                  advance;
	logic                  step;
	logic                  bank_hit;
	logic [BANK_IDX_W-1:0] bank_idx;
	logic [BANK_IDX_W-1:0] win_idx;
	logic [7:0]            rdata;
	logic                  claimed;
	logic                  high_bit;
	cbt_cmd_t              tcmd;
	cbt_tmr_t              tnxt;

	// Handshake: stage 1 moves on when the result register is free
	assign advance   = !valid_s2 || res.ready;
	assign step      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1   <= op_t'(cmd.opcode);
			off_s1  <= cmd.reg_offset;
			wd_s1   <= cmd.write_data;
			slot_s1 <= cmd.bank_slot;
			line_s1 <= cmd.scanline;
			dot_s1  <= cmd.ppu_dot;
		end
	end

	// Board variant register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 2'd0;
		end else if (cfg_we) begin
			variant_q <= cfg_wdata;
		end
	end

	// Timer
	assign tcmd.step = step;
	assign tcmd.op   = op_s1;
	assign tcmd.off  = off_s1;
	assign tcmd.wd   = wd_s1;
	assign tcmd.line = line_s1;
	assign tcmd.dot  = dot_s1;

	cbt_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tcmd),
		.nxt    (tnxt)
	);

	// Bank register decode
	assign bank_hit = off_s1 >= OFF_BANK
		&& {1'b0, off_s1} < 9'(int'(OFF_BANK) + BANK_SLOTS);
	assign bank_idx = BANK_IDX_W'(off_s1 - OFF_BANK);
	assign win_idx  = BANK_IDX_W'({2'd0, slot_s1} % 5'(BANK_SLOTS));

	// Write decode for the plain registers
	always_comb begin
		bank_win_n = bank_win_q;
		pcm_n      = pcm_q;
		mask_n     = mask_q;
		port_a_n   = port_a_q;
		port_b_n   = port_b_q;
		if (op_s1 == OP_WRITE) begin
			if (bank_hit) begin
				bank_win_n[bank_idx] = wd_s1;
			end else begin
				unique case (off_s1)
					OFF_PORT_A: port_a_n = wd_s1;
					OFF_PORT_B: port_b_n = wd_s1;
					OFF_PCM:    pcm_n    = wd_s1;
					OFF_MASK:   mask_n   = wd_s1;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_SLOTS; i++) begin
				bank_rd_q[i]  <= 8'(i);
				bank_win_q[i] <= 8'(i);
			end
			pcm_q    <= 8'd0;
			mask_q   <= MASK_RESET;
			port_a_q <= 8'd0;
			port_b_q <= PORT_B_RESET;
		end else if (step) begin
			bank_rd_q  <= bank_win_n;
			bank_win_q <= bank_win_n;
			pcm_q      <= pcm_n;
			mask_q     <= mask_n;
			port_a_q   <= port_a_n;
			port_b_q   <= port_b_n;
		end
	end

	// Read decode; a read changes no register, so timer next values are current
	always_comb begin
		rdata   = 8'd0;
		claimed = 1'b0;
		if (op_s1 == OP_READ) begin
			claimed = 1'b1;
			if (bank_hit) begin
				rdata = bank_rd_q[bank_idx];
			end else begin
				unique case (off_s1)
					OFF_PCM:    rdata = pcm_q;
					OFF_MASK:   rdata = mask_q;
					OFF_STATUS: rdata = {tnxt.flag, 7'd0};
					OFF_CTRL:   rdata = tnxt.ctrl;
					OFF_RELOAD: rdata = tnxt.reload;
					OFF_COUNT:  rdata = tnxt.count;
					default:    claimed = 1'b0;
				endcase
			end
		end
	end

	// Bank bit 8 source depends on the board variant
	assign high_bit = (variant_q == VARIANT_PORT_B) ? port_b_n[7] : port_a_n[1];

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rdata_s2   <= rdata;
			claimed_s2 <= claimed;
			irq_s2     <= tnxt.flag && !mask_n[7];
			bank_s2    <= {high_bit, bank_win_n[win_idx]};
			audio_s2   <= pcm_n;
		end
	end

	assign res.valid        = valid_s2;
	assign res.read_data    = rdata_s2;
	assign res.read_claimed = claimed_s2;
	assign res.irq_asserted = irq_s2;
	assign res.bank_number  = bank_s2;
	assign res.audio_level  = audio_s2;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for cartridge_bank_and_irq_timer: directed bus and timer
// tests, then random bus traffic under sender and receiver idling, checked word by word.
// Depends on cbt_pkg, cbt_in_if, cbt_out_if and the block itself.
module tb_top;
	import cbt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS  = 100;

	// Board variants beyond the port B one all behave as the default
	localparam logic [1:0] VARIANT_DEFAULT = 2'd0;
	localparam logic [1:0] VARIANT_SPARE_2 = 2'd2;
	localparam logic [1:0] VARIANT_SPARE_3 = 2'd3;

	// One expected result word
	typedef struct packed {
		logic [7:0] rd;
		logic       claimed;
		logic       irq;
		logic [8:0] bank;
		logic [7:0] audio;
	} reg_view_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	cbt_in_if  cmd_if ();
	cbt_out_if res_if ();

	cartridge_bank_and_irq_timer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.res       (res_if)
	);

	// Shadow copy of the register file
	logic [7:0] sh_bank [BANK_SLOTS];
	logic [7:0] sh_pcm;
	logic [7:0] sh_mask;
	logic       sh_flag;
	logic [7:0] sh_ctrl;
	logic [7:0] sh_reload;
	logic [7:0] sh_count;
	logic [7:0] sh_prescale;
	logic [8:0] sh_last_line;
	logic [7:0] sh_port_a;
	logic [7:0] sh_port_b;
	logic [1:0] sh_variant;

	reg_view_t pending_views[$];

	int errors         = 0;
	int words_sent     = 0;
	int views_checked  = 0;
	int irq_views      = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	logic [8:0] cur_line = '0;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_count,
				pending_views.size());
			$display("FAIL");
			$finish;
		end
	end

	// Receiver stalls
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (errors < MAX_REPORTS)
			$display("mismatch on %s in result %0d: got 0x%0h, expected 0x%0h",
				what, views_checked, got, want);
		errors++;
	endtask

	// ---------------- shadow register model ----------------

	task automatic reset_shadow();
		for (int i = 0; i < BANK_SLOTS; i++)
			sh_bank[i] = 8'(i);
		sh_pcm       = '0;
		sh_mask      = MASK_RESET;
		sh_flag      = 1'b0;
		sh_ctrl      = '0;
		sh_reload    = '0;
		sh_count     = '0;
		sh_prescale  = '0;
		sh_last_line = '0;
		sh_port_a    = '0;
		sh_port_b    = PORT_B_RESET;
		sh_variant   = VARIANT_DEFAULT;
	endtask

	// One prescaled timer clock
	function automatic void clock_timer();
		if (!sh_ctrl[CTRL_EN_BIT])
			return;
		sh_prescale = sh_prescale + 8'd1;
		if (sh_prescale < {4'd0, sh_ctrl[3:0]})
			return;
		sh_prescale = '0;
		if (sh_count == 8'd0) begin
			sh_count = sh_reload;
		end else begin
			sh_count = sh_count - 8'd1;
			if (sh_count == 8'd0) begin
				sh_flag = 1'b1;
				if (!sh_ctrl[CTRL_REPEAT_BIT])
					sh_ctrl[CTRL_EN_BIT] = 1'b0;
			end
		end
	endfunction

	function automatic void bus_store(logic [7:0] off, logic [7:0] wd);
		if (off >= OFF_BANK && off < OFF_BANK + BANK_SLOTS) begin
			sh_bank[off - OFF_BANK] = wd;
			return;
		end
		case (off)
			OFF_PORT_A: sh_port_a = wd;
			OFF_PORT_B: sh_port_b = wd;
			OFF_PCM:    sh_pcm = wd;
			OFF_MASK: begin
				sh_mask = wd;
				if (wd[7])
					sh_flag = 1'b0;
			end
			OFF_CTRL: begin
				sh_ctrl = wd;
				if (!wd[CTRL_EN_BIT])
					sh_flag = 1'b0;
			end
			OFF_RELOAD: begin
				sh_reload = wd;
				sh_count  = '0;
				sh_flag   = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic logic bus_fetch(logic [7:0] off, output logic [7:0] d);
		d = '0;
		if (off >= OFF_BANK && off < OFF_BANK + BANK_SLOTS) begin
			d = sh_bank[off - OFF_BANK];
			return 1'b1;
		end
		case (off)
			OFF_PCM:    d = sh_pcm;
			OFF_MASK:   d = sh_mask;
			OFF_STATUS: d = {sh_flag, 7'd0};
			OFF_CTRL:   d = sh_ctrl;
			OFF_RELOAD: d = sh_reload;
			OFF_COUNT:  d = sh_count;
			default:    return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Applies one accepted word to the shadow state and returns the result it yields
	function automatic reg_view_t apply_bus_word(op_t op, logic [7:0] off, logic [7:0] wd,
			logic [2:0] slot, logic [8:0] line, logic [8:0] dot);
		reg_view_t  v;
		logic [7:0] d;
		logic       hit;
		logic       high;
		d   = '0;
		hit = 1'b0;
		case (op)
			OP_WRITE: bus_store(off, wd);
			OP_READ:  hit = bus_fetch(off, d);
			OP_TICK: begin
				if (!sh_ctrl[CTRL_LINE_BIT])
					clock_timer();
			end
			OP_DOT: begin
				if (dot >= LINE_CLK_DOT && line != sh_last_line && sh_ctrl[CTRL_LINE_BIT]) begin
					sh_last_line = line;
					clock_timer();
				end
			end
			default: ;
		endcase
		high = (sh_variant == VARIANT_PORT_B) ? sh_port_b[7] : sh_port_a[1];
		v.rd      = hit ? d : 8'd0;
		v.claimed = hit;
		v.irq     = sh_flag && !sh_mask[7];
		v.bank    = {high, sh_bank[slot % BANK_SLOTS]};
		v.audio   = sh_pcm;
		return v;
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		reg_view_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_views.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_views.pop_front();
				if (res_if.read_data !== want.rd)
					report_mismatch("read_data", res_if.read_data, want.rd);
				if (res_if.read_claimed !== want.claimed)
					report_mismatch("read_claimed", res_if.read_claimed, want.claimed);
				if (res_if.irq_asserted !== want.irq)
					report_mismatch("irq_asserted", res_if.irq_asserted, want.irq);
				if (res_if.bank_number !== want.bank)
					report_mismatch("bank_number", res_if.bank_number, want.bank);
				if (res_if.audio_level !== want.audio)
					report_mismatch("audio_level", res_if.audio_level, want.audio);
				if (want.irq)
					irq_views++;
			end
			views_checked++;
		end
	end

	// ---------------- driving ----------------

	// Sends one word, with random idle cycles ahead of it
	task automatic send_word(op_t op, logic [7:0] off, logic [7:0] wd, logic [2:0] slot,
			logic [8:0] line, logic [8:0] dot);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.opcode     <= op;
		cmd_if.reg_offset <= off;
		cmd_if.write_data <= wd;
		cmd_if.bank_slot  <= slot;
		cmd_if.scanline   <= line;
		cmd_if.ppu_dot    <= dot;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		pending_views.push_back(apply_bus_word(op, off, wd, slot, line, dot));
		words_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
	endtask

	task automatic drain();
		drop_valid();
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// board_variant is only written once the block has gone quiet
	task automatic set_board_variant(logic [1:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sh_variant = v;
	endtask

	task automatic bus_wr(logic [7:0] off, logic [7:0] wd, logic [2:0] slot = 3'd0);
		send_word(OP_WRITE, off, wd, slot, 9'd0, 9'd0);
	endtask

	task automatic bus_rd(logic [7:0] off, logic [2:0] slot = 3'd0);
		send_word(OP_READ, off, 8'd0, slot, 9'd0, 9'd0);
	endtask

	// ---------------- directed tests ----------------

	task automatic test_reset_values();
		bus_rd(OFF_BANK + 8'(BANK_SLOTS - 1), 3'd7);
		bus_rd(OFF_MASK, 3'd0);
		bus_rd(OFF_STATUS);
		bus_rd(OFF_COUNT);
		bus_rd(OFF_PCM);
	endtask

	task automatic test_bus_decode();
		bus_wr(OFF_BANK + 8'(BANK_SLOTS - 1), 8'hFF);
		bus_wr(OFF_PCM, 8'hA5);
		// port A bit 1 drives bank bit 8 on the default board
		bus_wr(OFF_PORT_A, 8'h02, 3'd7);
		bus_rd(8'h00);
		bus_rd(8'hFF);
		// just past the last bank register: not decoded
		bus_rd(OFF_BANK + 8'(BANK_SLOTS), 3'd7);
		bus_wr(OFF_BANK + 8'(BANK_SLOTS), 8'h5A);
		bus_rd(OFF_RELOAD);
	endtask

	task automatic test_timer_cpu_mode();
		bus_wr(OFF_MASK, 8'h00);
		bus_wr(OFF_RELOAD, 8'h02);
		// enabled, one-shot, prescale 0
		bus_wr(OFF_CTRL, 8'h80);
		repeat (3) send_word(OP_TICK, 8'h00, 8'h00, 3'd0, 9'd0, 9'd0);
		// dot event while in cpu-cycle mode: ignored
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd3, 9'd300);
		bus_rd(OFF_STATUS);
	endtask

	task automatic test_timer_scanline_mode();
		bus_wr(OFF_CTRL, 8'hE0);
		send_word(OP_TICK, 8'h00, 8'h00, 3'd0, 9'd0, 9'd0);
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd1, 9'd279);
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd1, 9'd280);
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd1, 9'd340);
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd511, 9'd340);
		send_word(OP_DOT, 8'h00, 8'h00, 3'd0, 9'd0, 9'd300);
		// mask bit 7 clears the pending flag
		bus_wr(OFF_MASK, 8'h80);
	endtask

	// ---------------- random traffic ----------------

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(11))
			0:       return OFF_PORT_A;
			1:       return OFF_PORT_B;
			2:       return OFF_PCM;
			3:       return OFF_MASK;
			4:       return OFF_STATUS;
			5:       return OFF_CTRL;
			6:       return OFF_RELOAD;
			7:       return OFF_COUNT;
			8, 9:    return OFF_BANK + 8'($urandom_range(BANK_SLOTS - 1));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [8:0] next_scanline();
		if ($urandom_range(9) == 0)
			cur_line = 9'($urandom_range(511));
		else if ($urandom_range(2) != 0)
			cur_line = cur_line + 9'd1;
		return cur_line;
	endfunction

	function automatic logic [8:0] pick_dot();
		if ($urandom_range(1) == 0)
			return 9'($urandom_range(340, 280));
		return 9'($urandom_range(279));
	endfunction

	task automatic random_word();
		op_t op;
		int  r;
		r  = $urandom_range(99);
		op = (r < 30) ? OP_WRITE : (r < 55) ? OP_READ : (r < 85) ? OP_TICK : OP_DOT;
		send_word(op, pick_offset(), 8'($urandom_range(255)), 3'($urandom_range(7)),
			(op == OP_DOT) ? next_scanline() : 9'($urandom_range(511)), pick_dot());
	endtask

	// Timer set up with random content, then a run of clocks and status reads
	task automatic timer_burst();
		logic [7:0] ctrl;
		logic [7:0] mask;
		int         n_ev;
		int         r;
		mask    = 8'($urandom_range(255));
		mask[7] = ($urandom_range(3) == 0);
		ctrl    = 8'($urandom_range(255));
		ctrl[CTRL_EN_BIT]   = ($urandom_range(9) != 0);
		ctrl[CTRL_LINE_BIT] = ($urandom_range(2) == 0);
		ctrl[3:0] = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
		bus_wr(OFF_MASK, mask, 3'($urandom_range(7)));
		bus_wr(OFF_RELOAD, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
			: 8'($urandom_range(6)), 3'($urandom_range(7)));
		bus_wr(OFF_CTRL, ctrl, 3'($urandom_range(7)));
		n_ev = $urandom_range(30, 4);
		for (int k = 0; k < n_ev; k++) begin
			r = $urandom_range(99);
			if (r < 15)
				bus_rd(($urandom_range(1) == 0) ? OFF_STATUS : OFF_COUNT, 3'($urandom_range(7)));
			else if (r < 20)
				bus_rd(OFF_CTRL, 3'($urandom_range(7)));
			else if (ctrl[CTRL_LINE_BIT] && r < 90)
				send_word(OP_DOT, 8'($urandom_range(255)), 8'($urandom_range(255)),
					3'($urandom_range(7)), next_scanline(), pick_dot());
			else
				send_word(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
					3'($urandom_range(7)), 9'($urandom_range(511)), pick_dot());
		end
	endtask

	task automatic test_random_traffic(int n_words);
		int start;
		start = words_sent;
		while (words_sent - start < n_words) begin
			if ($urandom_range(5) == 0)
				timer_burst();
			else
				random_word();
		end
	endtask

	// ---------------- sequence ----------------

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		cmd_if.valid      = 1'b0;
		cmd_if.opcode     = '0;
		cmd_if.reg_offset = '0;
		cmd_if.write_data = '0;
		cmd_if.bank_slot  = '0;
		cmd_if.scanline   = '0;
		cmd_if.ppu_dot    = '0;
		res_if.ready      = 1'b0;
		reset_shadow();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_bus_decode();
		set_board_variant(VARIANT_PORT_B);
		bus_rd(OFF_CTRL, 3'd7);
		test_timer_cpu_mode();
		test_timer_scanline_mode();

		set_board_variant(VARIANT_DEFAULT);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(490);

		set_board_variant(VARIANT_PORT_B);
		send_idle_pct  = 70;
		recv_stall_pct = 0;
		test_random_traffic(490);

		set_board_variant(VARIANT_SPARE_2);
		send_idle_pct  = 0;
		recv_stall_pct = 70;
		test_random_traffic(490);

		set_board_variant(VARIANT_SPARE_3);
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		test_random_traffic(480);

		drain();
		$display("%0d words sent, %0d results checked (%0d with IRQ raised), %0d mismatches",
			words_sent, views_checked, irq_views, errors);
		$display("board variants 0-3, timer in cpu-cycle and scanline modes, four idling mixes");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
